// ----- sv/rmh_pkg.sv -----
// ============================================================================
// rmh_pkg
// Shared types, sizes and helpers for the running median (two heaps) block.
// ============================================================================
package rmh_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int DATA_W     = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CNT_W:0]    child_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        HOP_INSERT,
        HOP_POP,
        HOP_CLEAR
    } heap_op_t;

    typedef struct packed {
        logic     valid;
        heap_op_t op;
        logic     clear;
        data_t    value;
    } heap_cmd_t;

    typedef struct packed {
        logic  busy;
        cnt_t  count;
        data_t top;
    } heap_stat_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_INS,
        H_POP_LAST,
        H_POP_RD,
        H_FIN
    } heap_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_WAIT1,
        T_WAIT2,
        T_DONE
    } top_state_t;

    // True when a belongs nearer the top than b.
    function automatic logic outranks(input data_t a, input data_t b, input logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    function automatic idx_t parent(input idx_t i);
        return (i - idx_t'(1)) >> 1;
    endfunction

    function automatic child_t first_child(input idx_t i);
        return child_t'({i, 1'b1});
    endfunction

endpackage

// ----- sv/rmh_heap.sv -----
// ============================================================================
// rmh_heap
// One binary heap in a synchronous memory, with insert and remove-top
// sequencers that walk one tree level per cycle.
// ============================================================================
module rmh_heap (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               is_max,
    input  rmh_pkg::heap_cmd_t cmd,
    output rmh_pkg::heap_stat_t stat
);

    rmh_pkg::data_t heap_mem [rmh_pkg::HEAP_DEPTH];

    rmh_pkg::heap_state_t state_reg, state_next;
    rmh_pkg::idx_t  i_reg, i_next;
    rmh_pkg::data_t val_reg, val_next;
    rmh_pkg::cnt_t  cnt_reg, cnt_next;
    rmh_pkg::data_t top_reg;
    rmh_pkg::data_t rdata0_reg, rdata1_reg;

    logic           we;
    rmh_pkg::idx_t  waddr, raddr0, raddr1, par, cidx;
    rmh_pkg::data_t wdata, cval;
    rmh_pkg::cnt_t  ins_cnt, pop_cnt;
    rmh_pkg::child_t c, nc;
    logic           use_right;

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rdata0_reg <= heap_mem[raddr0];
        rdata1_reg <= heap_mem[raddr1];
        if (we && waddr == '0) begin
            top_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmh_pkg::H_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        i_reg   <= i_next;
        val_reg <= val_next;
    end

    always_comb begin
        ins_cnt   = cmd.clear ? '0 : cnt_reg;
        pop_cnt   = cnt_reg - rmh_pkg::cnt_t'(1);
        par       = rmh_pkg::parent(i_reg);
        c         = rmh_pkg::first_child(i_reg);
        use_right = ((c + rmh_pkg::child_t'(1)) < rmh_pkg::child_t'(cnt_reg)) &&
                    rmh_pkg::outranks(rdata1_reg, rdata0_reg, is_max);
        cval      = use_right ? rdata1_reg : rdata0_reg;
        cidx      = c[rmh_pkg::IDX_W-1:0] + rmh_pkg::idx_t'(use_right);
        nc        = rmh_pkg::first_child(cidx);

        state_next = state_reg;
        i_next     = i_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        we         = 1'b0;
        waddr      = i_reg;
        wdata      = val_reg;
        raddr0     = par;
        raddr1     = '0;

        unique case (state_reg)
            rmh_pkg::H_IDLE: begin
                if (cmd.valid) begin
                    unique case (cmd.op)
                        rmh_pkg::HOP_CLEAR: begin
                            cnt_next = '0;
                        end
                        rmh_pkg::HOP_INSERT: begin
                            cnt_next = ins_cnt + rmh_pkg::cnt_t'(1);
                            val_next = cmd.value;
                            i_next   = ins_cnt[rmh_pkg::IDX_W-1:0];
                            if (ins_cnt == '0) begin
                                we    = 1'b1;
                                waddr = '0;
                                wdata = cmd.value;
                            end else begin
                                raddr0     = rmh_pkg::parent(ins_cnt[rmh_pkg::IDX_W-1:0]);
                                state_next = rmh_pkg::H_INS;
                            end
                        end
                        rmh_pkg::HOP_POP: begin
                            cnt_next = pop_cnt;
                            i_next   = '0;
                            if (pop_cnt != '0) begin
                                raddr0     = pop_cnt[rmh_pkg::IDX_W-1:0];
                                state_next = rmh_pkg::H_POP_LAST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rmh_pkg::H_INS: begin
                we = 1'b1;
                if (rmh_pkg::outranks(val_reg, rdata0_reg, is_max)) begin
                    wdata  = rdata0_reg;
                    i_next = par;
                    if (par == '0) begin
                        state_next = rmh_pkg::H_FIN;
                    end else begin
                        raddr0 = rmh_pkg::parent(par);
                    end
                end else begin
                    state_next = rmh_pkg::H_IDLE;
                end
            end
            rmh_pkg::H_POP_LAST: begin
                // The old last entry is sifted down from the root.
                val_next = rdata0_reg;
                if (cnt_reg == rmh_pkg::cnt_t'(1)) begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rdata0_reg;
                    state_next = rmh_pkg::H_IDLE;
                end else begin
                    raddr0     = rmh_pkg::idx_t'(1);
                    raddr1     = rmh_pkg::idx_t'(2);
                    state_next = rmh_pkg::H_POP_RD;
                end
            end
            rmh_pkg::H_POP_RD: begin
                we = 1'b1;
                if (rmh_pkg::outranks(cval, val_reg, is_max)) begin
                    wdata  = cval;
                    i_next = cidx;
                    if (nc >= rmh_pkg::child_t'(cnt_reg)) begin
                        state_next = rmh_pkg::H_FIN;
                    end else begin
                        raddr0 = nc[rmh_pkg::IDX_W-1:0];
                        raddr1 = nc[rmh_pkg::IDX_W-1:0] + rmh_pkg::idx_t'(1);
                    end
                end else begin
                    state_next = rmh_pkg::H_IDLE;
                end
            end
            rmh_pkg::H_FIN: begin
                we         = 1'b1;
                state_next = rmh_pkg::H_IDLE;
            end
            default: begin
                state_next = rmh_pkg::H_IDLE;
            end
        endcase
    end

    assign stat.busy  = (state_reg != rmh_pkg::H_IDLE);
    assign stat.count = cnt_reg;
    assign stat.top   = top_reg;

endmodule

// ----- sv/running_median_two_heaps.sv -----
// ============================================================================
// running_median_two_heaps
// Running median of a signed sample stream, kept in a max-heap of the lower
// half and a min-heap of the upper half.
// ============================================================================
//
// Channel  Direction  tdata            tuser
// s_       in         sample[31:0]     start_new
// m_       out        median[31:0]     overflow
//
// The time a request takes is set by the sift walks through the heap memories,
// one tree level per cycle. A rebalance pops one heap while the moved top is
// sifted into the other at the same time; the new sample is then sifted in.
// Reset clears both heap counts and the stored median; heap contents need no
// clearing. One request is in flight at a time; a finished result waits in
// the output register while the next request is taken in, and that request
// holds its result back until the output register is free.
//
module running_median_two_heaps (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic        s_tuser,   // [0] start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] median
    output logic        m_tuser    // [0] overflow
);

    rmh_pkg::top_state_t state_reg, state_next;
    rmh_pkg::heap_cmd_t  lo_cmd, up_cmd;
    rmh_pkg::heap_stat_t lo_stat, up_stat;

    // Deferred insertion of the new sample after a rebalance.
    logic           pend_reg, pend_next;
    logic           pend_lo_reg, pend_lo_next;
    rmh_pkg::data_t pend_val_reg, pend_val_next;
    logic           ovf_reg, ovf_next;

    rmh_pkg::data_t median_reg, median_next;
    logic           m_tvalid_reg, m_tvalid_next;
    rmh_pkg::data_t m_tdata_reg;
    logic           m_tuser_reg;

    rmh_pkg::data_t  v;
    logic            lo_full, up_full, lo_gt, up_gt, load_out;
    logic signed [32:0] sum;
    logic signed [32:0] avg;
    rmh_pkg::data_t  med_calc;

    rmh_heap u_lower (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_max  (1'b1),
        .cmd     (lo_cmd),
        .stat    (lo_stat)
    );

    rmh_heap u_upper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_max  (1'b0),
        .cmd     (up_cmd),
        .stat    (up_stat)
    );

    assign v       = rmh_pkg::data_t'(s_tdata);
    assign lo_full = (lo_stat.count >= rmh_pkg::cnt_t'(rmh_pkg::HEAP_DEPTH));
    assign up_full = (up_stat.count >= rmh_pkg::cnt_t'(rmh_pkg::HEAP_DEPTH));
    assign lo_gt   = (lo_stat.count > up_stat.count);
    assign up_gt   = (up_stat.count > lo_stat.count);

    // Average of both tops over 33 bits, rounded toward zero.
    assign sum = 33'(lo_stat.top) + 33'(up_stat.top);
    assign avg = (sum + 33'(sum[32])) >>> 1;

    always_comb begin
        if (lo_gt) begin
            med_calc = lo_stat.top;
        end else if (up_gt) begin
            med_calc = up_stat.top;
        end else if (lo_stat.count != '0) begin
            med_calc = avg[31:0];
        end else begin
            med_calc = median_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rmh_pkg::T_IDLE;
            pend_reg     <= 1'b0;
            median_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            median_reg   <= median_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pend_lo_reg  <= pend_lo_next;
        pend_val_reg <= pend_val_next;
        ovf_reg      <= ovf_next;
        if (load_out) begin
            m_tdata_reg <= median_next;
            m_tuser_reg <= ovf_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        pend_lo_next  = pend_lo_reg;
        pend_val_next = pend_val_reg;
        ovf_next      = ovf_reg;
        median_next   = median_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load_out      = 1'b0;
        s_tready      = 1'b0;
        lo_cmd        = '{valid: 1'b0, op: rmh_pkg::HOP_INSERT, clear: 1'b0, value: v};
        up_cmd        = '{valid: 1'b0, op: rmh_pkg::HOP_INSERT, clear: 1'b0, value: v};

        unique case (state_reg)
            rmh_pkg::T_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ovf_next      = 1'b0;
                    pend_next     = 1'b0;
                    pend_val_next = v;
                    state_next    = rmh_pkg::T_WAIT1;
                    if (s_tuser) begin
                        lo_cmd.valid = 1'b1;
                        lo_cmd.clear = 1'b1;
                        up_cmd.valid = 1'b1;
                        up_cmd.op    = rmh_pkg::HOP_CLEAR;
                    end else if (v <= median_reg) begin
                        if (lo_gt) begin
                            if (up_full) begin
                                ovf_next   = 1'b1;
                                state_next = rmh_pkg::T_DONE;
                            end else begin
                                lo_cmd.valid = 1'b1;
                                lo_cmd.op    = rmh_pkg::HOP_POP;
                                up_cmd.valid = 1'b1;
                                up_cmd.value = lo_stat.top;
                                pend_next    = 1'b1;
                                pend_lo_next = 1'b1;
                            end
                        end else if (lo_full) begin
                            ovf_next   = 1'b1;
                            state_next = rmh_pkg::T_DONE;
                        end else begin
                            lo_cmd.valid = 1'b1;
                        end
                    end else begin
                        if (up_gt) begin
                            if (lo_full) begin
                                ovf_next   = 1'b1;
                                state_next = rmh_pkg::T_DONE;
                            end else begin
                                up_cmd.valid = 1'b1;
                                up_cmd.op    = rmh_pkg::HOP_POP;
                                lo_cmd.valid = 1'b1;
                                lo_cmd.value = up_stat.top;
                                pend_next    = 1'b1;
                                pend_lo_next = 1'b0;
                            end
                        end else if (up_full) begin
                            ovf_next   = 1'b1;
                            state_next = rmh_pkg::T_DONE;
                        end else begin
                            up_cmd.valid = 1'b1;
                        end
                    end
                end
            end
            rmh_pkg::T_WAIT1: begin
                if (!lo_stat.busy && !up_stat.busy) begin
                    if (pend_reg) begin
                        lo_cmd.value = pend_val_reg;
                        up_cmd.value = pend_val_reg;
                        lo_cmd.valid = pend_lo_reg;
                        up_cmd.valid = !pend_lo_reg;
                        pend_next    = 1'b0;
                        state_next   = rmh_pkg::T_WAIT2;
                    end else begin
                        state_next = rmh_pkg::T_DONE;
                    end
                end
            end
            rmh_pkg::T_WAIT2: begin
                if (!lo_stat.busy && !up_stat.busy) begin
                    state_next = rmh_pkg::T_DONE;
                end
            end
            rmh_pkg::T_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (!ovf_reg) begin
                        median_next = med_calc;
                    end
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = rmh_pkg::T_IDLE;
                end
            end
            default: begin
                state_next = rmh_pkg::T_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- tb/running_median_two_heaps_test.sv -----
// ============================================================================
// running_median_two_heaps_test
// Drives sample streams with random sequence starts into the running median
// block and checks every median and overflow flag against a two-heap
// predictor kept inside the testbench.
// ============================================================================
`timescale 1ns / 1ps

module running_median_two_heaps_test;

    localparam int DEPTH     = rmh_pkg::HEAP_DEPTH;
    localparam int MAX_CYC   = 4000000;
    localparam int DRAIN_CYC = 200;

    typedef struct packed {
        logic        start_new;
        logic [31:0] sample;
    } sample_req_t;

    typedef struct packed {
        logic [31:0] median;
        logic        overflow;
    } median_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    running_median_two_heaps DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // Predictor state: two heaps as unbounded queues, capped at DEPTH entries.
    int    lo_heap[$];
    int    hi_heap[$];
    int    run_median;

    sample_req_t pending_reqs[$];
    median_res_t expected_medians[$];
    bit          stim_done = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;

    // Max-heap when is_max is set, otherwise min-heap.
    function automatic bit ranks_above(int a, int b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    function automatic void heap_push(ref int h[$], input int v, input bit is_max);
        int i;
        int p;
        h.push_back(v);
        i = h.size() - 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_above(v, h[p], is_max)) break;
            h[i] = h[p];
            i = p;
        end
        h[i] = v;
    endfunction

    function automatic int heap_pop(ref int h[$], input bit is_max);
        int top;
        int last;
        int n;
        int i;
        int c;
        top  = h[0];
        last = h.pop_back();
        n    = h.size();
        i    = 0;
        forever begin
            c = 2 * i + 1;
            if (c >= n) break;
            if (c + 1 < n && ranks_above(h[c + 1], h[c], is_max)) c++;
            if (!ranks_above(h[c], last, is_max)) break;
            h[i] = h[c];
            i = c;
        end
        if (n > 0) h[i] = last;
        return top;
    endfunction

    function automatic median_res_t predict_median(sample_req_t rq);
        median_res_t r;
        int          v;
        bit          ovf;
        longint      s;
        v   = $signed(rq.sample);
        ovf = 1'b0;
        if (rq.start_new) begin
            lo_heap.delete();
            hi_heap.delete();
            heap_push(lo_heap, v, 1'b1);
        end else if (v <= run_median) begin
            if (lo_heap.size() > hi_heap.size()) begin
                if (hi_heap.size() >= DEPTH) ovf = 1'b1;
                else begin
                    heap_push(hi_heap, heap_pop(lo_heap, 1'b1), 1'b0);
                    heap_push(lo_heap, v, 1'b1);
                end
            end else if (lo_heap.size() >= DEPTH) ovf = 1'b1;
            else heap_push(lo_heap, v, 1'b1);
        end else begin
            if (hi_heap.size() > lo_heap.size()) begin
                if (lo_heap.size() >= DEPTH) ovf = 1'b1;
                else begin
                    heap_push(lo_heap, heap_pop(hi_heap, 1'b0), 1'b1);
                    heap_push(hi_heap, v, 1'b0);
                end
            end else if (hi_heap.size() >= DEPTH) ovf = 1'b1;
            else heap_push(hi_heap, v, 1'b0);
        end
        if (!ovf) begin
            if (lo_heap.size() > hi_heap.size()) run_median = lo_heap[0];
            else if (hi_heap.size() > lo_heap.size()) run_median = hi_heap[0];
            else if (lo_heap.size() > 0) begin
                s = longint'(lo_heap[0]) + longint'(hi_heap[0]);
                run_median = int'(s / 2);
            end
        end
        r.median   = run_median;
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(bit st, logic [31:0] smp);
        sample_req_t rq;
        rq.start_new = st;
        rq.sample    = smp;
        pending_reqs.push_back(rq);
    endtask

    initial begin
        int n;
        run_median = 0;
        // Samples before any start, against an empty set and median zero.
        add_req(1'b0, 32'd5);
        add_req(1'b0, 32'hFFFF_FFFB);
        add_req(1'b0, 32'h7FFF_FFFF);
        // Extremes: both tops at the limits, sums that need the 33rd bit.
        add_req(1'b1, 32'h8000_0000);
        add_req(1'b0, 32'h8000_0000);
        add_req(1'b0, 32'h7FFF_FFFF);
        add_req(1'b0, 32'h7FFF_FFFF);
        add_req(1'b1, 32'h7FFF_FFFF);
        add_req(1'b0, 32'h7FFF_FFFF);
        add_req(1'b1, 32'hFFFF_FFFF);
        add_req(1'b0, 32'd0);          // average of -1 and 0 truncates to 0
        add_req(1'b1, 32'hFFFF_FFFD);
        add_req(1'b0, 32'd0);
        for (int i = 0; i < 8; i++) add_req(1'b0, 32'($signed(i * 7 - 20)));
        // Random sequences, mostly short, of random content.
        n = pending_reqs.size();
        while (n < 600) begin
            add_req(1'b1, rand_sample());
            n++;
            repeat ($urandom_range(0, 30)) begin
                add_req($urandom_range(0, 40) == 0, rand_sample());
                n++;
            end
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of requests with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_medians.push_back(predict_median({s_tuser, s_tdata}));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_tuser  <= pending_reqs[0].start_new;
                s_tdata  <= pending_reqs[0].sample;
                void'(pending_reqs.pop_front());
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: the receiver stalls in four patterns that take turns.
    always @(posedge aclk) begin
        median_res_t exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: median %h overflow %b", m_tdata, m_tuser);
            end else begin
                exp_r = expected_medians.pop_front();
                if (exp_r.median !== m_tdata || exp_r.overflow !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: median exp %h got %h, overflow exp %b got %b",
                                 exp_r.median, m_tdata, exp_r.overflow, m_tuser);
                end
            end
        end
        stall_phase <= (cycles / 300) % 4;
        case (stall_phase)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles % 37) > 20);
        endcase
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && pending_reqs.size() == 0 && !s_tvalid
                 && expected_medians.size() == 0) && cycles < MAX_CYC)
            @(posedge aclk);
        if (cycles >= MAX_CYC) begin
            $display("running_median_two_heaps_test NOT OK");
            $finish;
        end else begin
            repeat (DRAIN_CYC) @(posedge aclk);
            if (mismatches == 0 && expected_medians.size() == 0)
                $display("running_median_two_heaps_test OK");
            else
                $display("running_median_two_heaps_test NOT OK");
            $finish;
        end
    end

endmodule
